// ===== rtl/core/ade_pkg.sv =====
// ----------------------------------------------------------------------------
// ade_pkg: shared types and constants of the attack/decay envelope
// Register map, stage codes, sequencer states and configuration bundle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ade_pkg;

   localparam int REG_WIDTH         = 24;
   localparam int RECIP_BITS        = 24;
   localparam int OUT_WIDTH         = 24;
   localparam int STAGE_WIDTH       = 2;
   localparam int CSR_INDEX_WIDTH   = 3;
   localparam int DEF_COUNT_WIDTH   = 24;
   localparam int DEF_FRACTION_BITS = 23;

   localparam logic [REG_WIDTH-1:0] RST_RISE_SAMPLES    = 24'd2400;
   localparam logic [REG_WIDTH-1:0] RST_FALL_SAMPLES    = 24'd2400;
   localparam logic [REG_WIDTH-1:0] RST_IDLE_SAMPLES    = 24'd2400;
   localparam logic [REG_WIDTH-1:0] RST_RISE_RECIPROCAL = 24'd6991;
   localparam logic [REG_WIDTH-1:0] RST_FALL_RECIPROCAL = 24'd6991;
   localparam logic signed [REG_WIDTH-1:0] RST_OUT_MIN  = 24'sd0;
   localparam logic signed [REG_WIDTH-1:0] RST_OUT_MAX  = 24'sd8388607;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_RISE_SAMPLES    = 3'd0,
      CSR_FALL_SAMPLES    = 3'd1,
      CSR_IDLE_SAMPLES    = 3'd2,
      CSR_RISE_RECIPROCAL = 3'd3,
      CSR_FALL_RECIPROCAL = 3'd4,
      CSR_OUT_MIN         = 3'd5,
      CSR_OUT_MAX         = 3'd6
   } csr_index_type;

   typedef enum logic [STAGE_WIDTH-1:0] {
      STAGE_IDLE = 2'd0,
      STAGE_RISE = 2'd1,
      STAGE_FALL = 2'd2
   } stage_type;

   typedef enum logic [2:0] {
      ST_WAIT,
      ST_RECIP,
      ST_LEVEL_GO,
      ST_LEVEL,
      ST_OUT_GO,
      ST_OUT,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      MUL_RECIP,
      MUL_LEVEL,
      MUL_OUT
   } mul_sel_type;

   typedef struct packed {
      logic [REG_WIDTH-1:0]        rise_samples;
      logic [REG_WIDTH-1:0]        fall_samples;
      logic [REG_WIDTH-1:0]        idle_samples;
      logic [REG_WIDTH-1:0]        rise_reciprocal;
      logic [REG_WIDTH-1:0]        fall_reciprocal;
      logic signed [REG_WIDTH-1:0] out_min;
      logic signed [REG_WIDTH-1:0] out_max;
   } cfg_type;

endpackage

// ===== rtl/core/ade_csr.sv =====
// ----------------------------------------------------------------------------
// ade_csr: configuration registers
// Holds the stage lengths, reciprocals and output range written over csr_.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ade_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [ade_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [ade_pkg::REG_WIDTH-1:0]       csr_wdata,
   output ade_pkg::cfg_type                    cfg
);
   import ade_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_RISE_SAMPLES:    cfg_in.rise_samples    = csr_wdata;
            CSR_FALL_SAMPLES:    cfg_in.fall_samples    = csr_wdata;
            CSR_IDLE_SAMPLES:    cfg_in.idle_samples    = csr_wdata;
            CSR_RISE_RECIPROCAL: cfg_in.rise_reciprocal = csr_wdata;
            CSR_FALL_RECIPROCAL: cfg_in.fall_reciprocal = csr_wdata;
            CSR_OUT_MIN:         cfg_in.out_min         = signed'(csr_wdata);
            CSR_OUT_MAX:         cfg_in.out_max         = signed'(csr_wdata);
            default:             cfg_in                 = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rise_samples    <= RST_RISE_SAMPLES;
         cfg_ff.fall_samples    <= RST_FALL_SAMPLES;
         cfg_ff.idle_samples    <= RST_IDLE_SAMPLES;
         cfg_ff.rise_reciprocal <= RST_RISE_RECIPROCAL;
         cfg_ff.fall_reciprocal <= RST_FALL_RECIPROCAL;
         cfg_ff.out_min         <= RST_OUT_MIN;
         cfg_ff.out_max         <= RST_OUT_MAX;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== rtl/core/ade_serial_mul.sv =====
// ----------------------------------------------------------------------------
// ade_serial_mul: bit-serial shift-add multiplier
// Signed multiplicand times unsigned multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ade_serial_mul #(
   parameter int AW = 25,
   parameter int BW = 24
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic signed [AW-1:0]    a,
   input  logic [BW-1:0]           b,
   output logic                    done,
   output logic signed [AW+BW-1:0] product
);
   import ade_pkg::*;

   localparam int CNTW = $clog2(BW + 1);

   logic signed [AW-1:0] a_ff;
   logic signed [AW-1:0] a_in;
   logic signed [AW-1:0] hi_ff;
   logic signed [AW-1:0] hi_in;
   logic [BW-1:0]        lo_ff;
   logic [BW-1:0]        lo_in;
   logic [CNTW-1:0]      cnt_ff;
   logic [CNTW-1:0]      cnt_in;
   logic                 done_ff;
   logic                 done_in;
   logic [AW:0]          sum_w;

   assign sum_w = {hi_ff[AW-1], hi_ff} + (lo_ff[0] ? {a_ff[AW-1], a_ff} : '0);

   always_comb begin
      a_in    = a_ff;
      hi_in   = hi_ff;
      lo_in   = lo_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         a_in   = a;
         hi_in  = '0;
         lo_in  = b;
         cnt_in = CNTW'(BW);
      end else if (cnt_ff != '0) begin
         hi_in   = signed'(sum_w[AW:1]);
         lo_in   = {sum_w[0], lo_ff[BW-1:1]};
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == CNTW'(1));
      end
   end

   always_ff @(posedge clock) begin
      a_ff  <= a_in;
      hi_ff <= hi_in;
      lo_ff <= lo_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   assign done    = done_ff;
   assign product = {hi_ff, lo_ff};

endmodule

// ===== rtl/core/attack_decay_envelope.sv =====
// ----------------------------------------------------------------------------
// attack_decay_envelope: one-shot attack/decay envelope generator
// Products: step (on a trigger or end of rise), then level, then output, in
//   turn on one bit-serial multiplier, BW = max(FRACTION_BITS+1, 24) bits.
// One item at a time: a new request is taken only after the last result is
//   in the response register, which waits until the response slot is free.
// Reset: stage idle, phase zero, level about 0.0001, multiplier one,
//   configuration registers at their defaults, no result pending.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module attack_decay_envelope #(
   parameter int COUNT_WIDTH   = ade_pkg::DEF_COUNT_WIDTH,
   parameter int FRACTION_BITS = ade_pkg::DEF_FRACTION_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_trigger,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [ade_pkg::OUT_WIDTH-1:0] rsp_envelope_value,
   output logic [ade_pkg::STAGE_WIDTH-1:0]     rsp_stage_now,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [ade_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [ade_pkg::REG_WIDTH-1:0]       csr_wdata
);
   import ade_pkg::*;

   localparam int LW   = FRACTION_BITS + 1;
   localparam int AW   = (FRACTION_BITS + 2 > REG_WIDTH + 1) ? FRACTION_BITS + 2
                                                             : REG_WIDTH + 1;
   localparam int BW   = (LW > RECIP_BITS) ? LW : RECIP_BITS;
   localparam int PW   = AW + BW;
   localparam int CMPW = (COUNT_WIDTH > REG_WIDTH) ? COUNT_WIDTH : REG_WIDTH;
   localparam int VW   = OUT_WIDTH + 3;

   localparam longint ONE_L = longint'(1) << FRACTION_BITS;
   localparam logic [LW-1:0] ONE_Q       = LW'(ONE_L);
   localparam logic [LW-1:0] LEVEL_RESET = LW'((ONE_L + 64'd5000) / 64'd10000);
   localparam logic [LW-1:0] K_FALL      = LW'((ONE_L * 64'd9999 + 64'd5000) / 64'd10000);
   localparam logic [PW:0]   RECIP_HALF  = (PW+1)'(1) << (RECIP_BITS - 1);
   localparam logic [PW:0]   LEVEL_HALF  = (PW+1)'(1) << (FRACTION_BITS - 1);
   localparam logic signed [VW-1:0] OUT_HI = VW'((longint'(1) << (OUT_WIDTH - 1)) - 1);
   localparam logic signed [VW-1:0] OUT_LO = -VW'(longint'(1) << (OUT_WIDTH - 1));

   cfg_type cfg;

   state_type state_ff;
   state_type state_in;

   stage_type             stage_ff;
   stage_type             stage_in;
   logic [COUNT_WIDTH-1:0] phase_ff;
   logic [COUNT_WIDTH-1:0] phase_in;
   logic [LW-1:0]          level_ff;
   logic [LW-1:0]          level_in;
   logic [LW-1:0]          mult_ff;
   logic [LW-1:0]          mult_in;
   logic                   recip_fall_ff;
   logic                   recip_fall_in;

   logic                         rsp_valid_ff;
   logic                         rsp_valid_in;
   logic signed [OUT_WIDTH-1:0]  rsp_value_ff;
   logic signed [OUT_WIDTH-1:0]  rsp_value_in;
   logic [STAGE_WIDTH-1:0]       rsp_stage_ff;
   logic [STAGE_WIDTH-1:0]       rsp_stage_in;

   logic        load_state;
   logic        load_mult;
   logic        load_level;
   logic        load_rsp;
   logic        mul_start;
   mul_sel_type mul_sel;
   logic        slot_free;

   stage_type              stage_a;
   logic [COUNT_WIDTH-1:0] phase_a;
   logic [REG_WIDTH-1:0]   len;
   logic                   stage_end;
   stage_type              stage_n;
   logic [COUNT_WIDTH-1:0] phase_mid;
   logic [LW-1:0]          level_n;
   logic [LW-1:0]          mult_n;
   logic                   need_recip;
   logic                   recip_fall_n;

   logic signed [AW-1:0]   mul_a;
   logic [BW-1:0]          mul_b;
   logic                   mul_done;
   logic signed [PW-1:0]   prod;
   logic [LW-1:0]          level_clip;
   logic signed [REG_WIDTH:0] diff;

   logic [PW:0]            prod_ext;
   logic [PW:0]            rsum;
   logic [PW:0]            lsum;
   logic [LW-1:0]          r_val;
   logic [LW:0]            m_wide;
   logic [LW-1:0]          mult_post;
   logic [LW:0]            lv;
   logic [LW-1:0]          level_post;
   logic signed [VW-1:0]   v_scaled;
   logic signed [VW-1:0]   v_sum;
   logic signed [OUT_WIDTH-1:0] v_sat;

   ade_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   ade_serial_mul #(
      .AW (AW),
      .BW (BW)
   ) u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .a       (mul_a),
      .b       (mul_b),
      .done    (mul_done),
      .product (prod)
   );

   // Stage decision for the item on the input port
   always_comb begin
      stage_a = req_trigger ? STAGE_RISE : stage_ff;
      phase_a = req_trigger ? '0 : phase_ff;
      case (stage_a)
         STAGE_RISE: len = cfg.rise_samples;
         STAGE_FALL: len = cfg.fall_samples;
         default:    len = cfg.idle_samples;
      endcase
      stage_end = (CMPW'(phase_a) >= CMPW'(len));

      stage_n      = stage_a;
      phase_mid    = phase_a;
      level_n      = level_ff;
      mult_n       = mult_ff;
      need_recip   = req_trigger;
      recip_fall_n = 1'b0;
      if (stage_end) begin
         phase_mid = '0;
         case (stage_a)
            STAGE_RISE: begin
               stage_n      = STAGE_FALL;
               level_n      = ONE_Q;
               need_recip   = 1'b1;
               recip_fall_n = 1'b1;
            end
            STAGE_FALL: begin
               stage_n    = STAGE_IDLE;
               level_n    = '0;
               mult_n     = ONE_Q;
               need_recip = 1'b0;
            end
            default: begin
               stage_n    = STAGE_IDLE;
               level_n    = '0;
               mult_n     = '0;
               need_recip = 1'b0;
            end
         endcase
      end
   end

   // Multiplier operands
   assign level_clip = (level_ff > ONE_Q) ? ONE_Q : level_ff;
   assign diff = {cfg.out_max[REG_WIDTH-1], cfg.out_max}
               - {cfg.out_min[REG_WIDTH-1], cfg.out_min};

   always_comb begin
      case (mul_sel)
         MUL_RECIP: begin
            if (recip_fall_n) begin
               mul_a = signed'(AW'(K_FALL));
               mul_b = BW'(cfg.fall_reciprocal);
            end else begin
               mul_a = signed'(AW'(ONE_Q - level_clip));
               mul_b = BW'(cfg.rise_reciprocal);
            end
         end
         MUL_LEVEL: begin
            mul_a = signed'(AW'(level_ff));
            mul_b = BW'(mult_ff);
         end
         MUL_OUT: begin
            mul_a = AW'(diff);
            mul_b = BW'(level_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // Product rounding and saturation
   always_comb begin
      prod_ext = {prod[PW-1], prod};
      rsum     = prod_ext + RECIP_HALF;
      lsum     = prod_ext + LEVEL_HALF;
      r_val    = rsum[RECIP_BITS +: LW];
      if (recip_fall_ff) begin
         m_wide    = '0;
         mult_post = (r_val >= ONE_Q) ? '0 : ONE_Q - r_val;
      end else begin
         m_wide    = {1'b0, r_val} + {1'b0, ONE_Q};
         mult_post = m_wide[LW] ? '1 : m_wide[LW-1:0];
      end
      lv         = lsum[FRACTION_BITS +: LW+1];
      level_post = (lv > {1'b0, ONE_Q}) ? ONE_Q : lv[LW-1:0];
      v_scaled   = signed'(lsum[FRACTION_BITS +: VW]);
      v_sum      = v_scaled + VW'(cfg.out_min);
      if (v_sum > OUT_HI) begin
         v_sat = OUT_HI[OUT_WIDTH-1:0];
      end else if (v_sum < OUT_LO) begin
         v_sat = OUT_LO[OUT_WIDTH-1:0];
      end else begin
         v_sat = v_sum[OUT_WIDTH-1:0];
      end
   end

   assign slot_free = !rsp_valid_ff || rsp_ready;

   // Sequencer next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_WAIT: begin
            if (req_valid) begin
               state_in = need_recip ? ST_RECIP : ST_LEVEL_GO;
            end
         end
         ST_RECIP: begin
            if (mul_done) begin
               state_in = ST_LEVEL_GO;
            end
         end
         ST_LEVEL_GO: state_in = ST_LEVEL;
         ST_LEVEL: begin
            if (mul_done) begin
               state_in = ST_OUT_GO;
            end
         end
         ST_OUT_GO: state_in = ST_OUT;
         ST_OUT: begin
            if (mul_done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (slot_free) begin
               state_in = ST_WAIT;
            end
         end
         default: state_in = ST_WAIT;
      endcase
   end

   // Sequencer outputs
   always_comb begin
      req_ready  = 1'b0;
      load_state = 1'b0;
      load_mult  = 1'b0;
      load_level = 1'b0;
      load_rsp   = 1'b0;
      mul_start  = 1'b0;
      mul_sel    = MUL_RECIP;
      case (state_ff)
         ST_WAIT: begin
            req_ready  = 1'b1;
            load_state = req_valid;
            mul_start  = req_valid && need_recip;
         end
         ST_RECIP:    load_mult = mul_done;
         ST_LEVEL_GO: begin
            mul_start = 1'b1;
            mul_sel   = MUL_LEVEL;
         end
         ST_LEVEL:    load_level = mul_done;
         ST_OUT_GO: begin
            mul_start = 1'b1;
            mul_sel   = MUL_OUT;
         end
         ST_DONE:     load_rsp = slot_free;
         default:     req_ready = 1'b0;
      endcase
   end

   // Envelope state and result register
   always_comb begin
      stage_in      = stage_ff;
      phase_in      = phase_ff;
      level_in      = level_ff;
      mult_in       = mult_ff;
      recip_fall_in = recip_fall_ff;
      if (load_state) begin
         stage_in      = stage_n;
         phase_in      = (phase_mid != '1) ? phase_mid + 1'b1 : phase_mid;
         level_in      = level_n;
         mult_in       = mult_n;
         recip_fall_in = recip_fall_n;
      end
      if (load_mult) begin
         mult_in = mult_post;
      end
      if (load_level) begin
         level_in = level_post;
      end

      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_value_in = rsp_value_ff;
      rsp_stage_in = rsp_stage_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_value_in = v_sat;
         rsp_stage_in = stage_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_WAIT;
         stage_ff      <= STAGE_IDLE;
         phase_ff      <= '0;
         level_ff      <= LEVEL_RESET;
         mult_ff       <= ONE_Q;
         recip_fall_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         stage_ff      <= stage_in;
         phase_ff      <= phase_in;
         level_ff      <= level_in;
         mult_ff       <= mult_in;
         recip_fall_ff <= recip_fall_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_value_ff <= rsp_value_in;
      rsp_stage_ff <= rsp_stage_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_envelope_value = rsp_value_ff;
   assign rsp_stage_now      = rsp_stage_ff;

endmodule
